/* src/nsc_pkg.sv */
// Shared types, constants and helper functions for the NMEA sentence checker.
`timescale 1ns / 1ps
package nsc_pkg;

	localparam int MAX_TYPE_CHARS = 5;
	localparam int POS_W          = $clog2(MAX_TYPE_CHARS + 1);
	localparam int TYPE_W         = 40;
	localparam int LEN_W          = 3;
	localparam int CFG_DATA_W     = 40;
	localparam int CFG_IDX_W      = 1;
	localparam int TYPE_EXT_W     = 128;

	localparam logic [CFG_IDX_W-1:0] REG_TYPE_CHARS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_LEN   = 1'd1;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [TYPE_W-1:0] TYPE_CHARS_RST = 40'd4278087;
	localparam logic [LEN_W-1:0]  TYPE_LEN_RST   = 3'd3;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_TALK1 = 3'd1,
		PH_TALK2 = 3'd2,
		PH_BODY  = 3'd3,
		PH_HEX1  = 3'd4,
		PH_HEX2  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_TALKER  = 2'd1,
		ERR_CONTROL = 2'd2,
		ERR_HEX     = 2'd3
	} err_t;

	typedef struct packed {
		logic       framing_ok;
		err_t       error_code;
		logic       checksum_ok;
		logic       type_match;
		logic       constellation;
		logic [7:0] computed_sum;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h.ok     = 1'b1;
		h.nibble = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.nibble = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.nibble = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.nibble = 4'(c - 8'h57);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	function automatic logic [7:0] type_byte(input logic [TYPE_W-1:0] chars,
						 input logic [POS_W-1:0] pos);
		logic [TYPE_EXT_W-1:0] ext;
		ext = TYPE_EXT_W'(chars);
		return ext[{pos, 3'b000} +: 8];
	endfunction

	function automatic logic [POS_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [POS_W-1:0] r;
		if (32'(len) > MAX_TYPE_CHARS) begin
			r = POS_W'(MAX_TYPE_CHARS);
		end else begin
			r = POS_W'(len);
		end
		return r;
	endfunction

endpackage

/* src/nmea_sentence_checker.sv */
// Top level of the NMEA 0183 sentence checker.
//
// Characters enter on the input channel (in_valid, in_stall, character), one
// byte per transfer. Bytes before a '$' are discarded. Each sentence, whether
// complete or failed, yields one transfer on the output channel (out_valid,
// out_stall and the result fields); hunting bytes yield nothing.
// A byte taken sits in the input register; its result, if any, is then loaded
// into the result register, and out_valid rises with that load.
// Throughput is one byte per cycle, but for the stall below: the per-byte state
// update is a single level of logic between the input and result registers.
// When the receiver stalls with a result waiting, a following byte that would
// also finish a sentence waits in the input register and in_stall rises;
// bytes that finish nothing keep flowing.
// The configuration port writes type_chars (index 0) and type_len (index 1);
// the user must write it only while the block is idle; it is not enforced.
// Reset clears the state machine to hunting, empties both registers and
// restores the default sentence type.
`timescale 1ns / 1ps
module nmea_sentence_checker
	import nsc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            character,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  framing_ok,
	output logic [1:0]            error_code,
	output logic                  checksum_ok,
	output logic                  type_match,
	output logic                  constellation,
	output logic [7:0]            computed_sum
);

	logic [TYPE_W-1:0] type_chars_q;
	logic [LEN_W-1:0]  type_len_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       emit;
	logic       free;
	logic       advance;
	res_t       res_c;
	res_t       res_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_chars_q <= TYPE_CHARS_RST;
			type_len_q   <= TYPE_LEN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TYPE_CHARS: type_chars_q <= cfg_data[TYPE_W-1:0];
				REG_TYPE_LEN:   type_len_q   <= cfg_data[LEN_W-1:0];
				default:        type_len_q   <= type_len_q;
			endcase
		end
	end

	assign advance  = valid_s1 && (!emit || free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= character;
		end
	end

	nsc_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.char_in    (char_s1),
		.type_chars (type_chars_q),
		.type_len   (type_len_q),
		.emit       (emit),
		.res        (res_c)
	);

	nsc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.res_in    (res_c),
		.out_stall (out_stall),
		.free      (free),
		.out_valid (out_valid),
		.res_out   (res_o)
	);

	assign framing_ok    = res_o.framing_ok;
	assign error_code    = res_o.error_code;
	assign checksum_ok   = res_o.checksum_ok;
	assign type_match    = res_o.type_match;
	assign constellation = res_o.constellation;
	assign computed_sum  = res_o.computed_sum;

endmodule

/* src/nsc_fsm.sv */
// Sentence state machine: phase, running XOR, type comparison and result forming.
`timescale 1ns / 1ps
module nsc_fsm
	import nsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_in,
	input  logic [TYPE_W-1:0] type_chars,
	input  logic [LEN_W-1:0]  type_len,
	output logic              emit,
	output res_t              res
);

	phase_t           phase_q, phase_d;
	logic [7:0]       xor_q, xor_d;
	logic [3:0]       hi_q, hi_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic             mism_q, mism_d;
	logic             glo_q, glo_d;

	logic [POS_W-1:0] len_eff;
	logic             in_type;
	hex_t             hx;

	assign len_eff = eff_len(type_len);
	assign in_type = pos_q < len_eff;
	assign hx      = hex_value(char_in);

	always_comb begin
		phase_d = phase_q;
		xor_d   = xor_q;
		hi_d    = hi_q;
		pos_d   = pos_q;
		mism_d  = mism_q;
		glo_d   = glo_q;
		case (phase_q)
			PH_TALK1: begin
				if (char_in == CH_G) begin
					xor_d   = xor_q ^ char_in;
					phase_d = PH_TALK2;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_TALK2: begin
				if (char_in == CH_P || char_in == CH_L) begin
					glo_d   = (char_in == CH_L);
					xor_d   = xor_q ^ char_in;
					phase_d = PH_BODY;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				if (char_in == CH_STAR) begin
					if (in_type) begin
						mism_d = 1'b1;
					end
					phase_d = PH_HEX1;
				end else if (char_in < CH_SPACE) begin
					phase_d = PH_HUNT;
				end else begin
					xor_d = xor_q ^ char_in;
					if (in_type) begin
						if (type_byte(type_chars, pos_q) != char_in) begin
							mism_d = 1'b1;
						end
						pos_d = pos_q + 1'b1;
					end
				end
			end
			PH_HEX1: begin
				if (hx.ok) begin
					hi_d    = hx.nibble;
					phase_d = PH_HEX2;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_HEX2: begin
				phase_d = PH_HUNT;
			end
			default: begin
				if (char_in == CH_DOLLAR) begin
					xor_d   = 8'd0;
					hi_d    = 4'd0;
					pos_d   = '0;
					mism_d  = 1'b0;
					glo_d   = 1'b0;
					phase_d = PH_TALK1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_comb begin
		emit               = 1'b0;
		res.error_code     = ERR_NONE;
		res.checksum_ok    = 1'b0;
		res.type_match     = 1'b0;
		res.constellation  = glo_q;
		res.computed_sum   = xor_q;
		case (phase_q)
			PH_TALK1: begin
				if (char_in != CH_G) begin
					emit           = 1'b1;
					res.error_code = ERR_TALKER;
				end
			end
			PH_TALK2: begin
				if (char_in != CH_P && char_in != CH_L) begin
					emit           = 1'b1;
					res.error_code = ERR_TALKER;
				end
			end
			PH_BODY: begin
				if (char_in != CH_STAR && char_in < CH_SPACE) begin
					emit           = 1'b1;
					res.error_code = ERR_CONTROL;
				end
			end
			PH_HEX1: begin
				if (!hx.ok) begin
					emit           = 1'b1;
					res.error_code = ERR_HEX;
				end
			end
			PH_HEX2: begin
				emit = 1'b1;
				if (hx.ok) begin
					res.checksum_ok = ({hi_q, hx.nibble} == xor_q);
					res.type_match  = !mism_q;
				end else begin
					res.error_code = ERR_HEX;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		res.framing_ok = (res.error_code == ERR_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			xor_q   <= 8'd0;
			hi_q    <= 4'd0;
			pos_q   <= '0;
			mism_q  <= 1'b0;
			glo_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			hi_q    <= hi_d;
			pos_q   <= pos_d;
			mism_q  <= mism_d;
			glo_q   <= glo_d;
		end
	end

endmodule

/* src/nsc_out_reg.sv */
// Result register holding one finished result until the receiver takes it.
`timescale 1ns / 1ps
module nsc_out_reg
	import nsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  res_t res_in,
	input  logic out_stall,
	output logic free,
	output logic out_valid,
	output res_t res_out
);

	logic valid_q;
	res_t res_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

/* src/nsc_checker.sv */
// Port-level assertions for the sentence checker and the bind that attaches them.
`timescale 1ns / 1ps
module nsc_checker
	import nsc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       framing_ok,
	input logic [1:0] error_code,
	input logic       checksum_ok,
	input logic       type_match,
	input logic       constellation
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	a_framing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> framing_ok == (error_code == ERR_NONE))
		else $error("framing flag disagrees with error code");

	a_fail_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !framing_ok |-> !checksum_ok && !type_match)
		else $error("failed sentence reports checksum or type match");

	a_talker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code == ERR_TALKER |-> !constellation)
		else $error("talker failure reports a GLONASS talker");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.framing_ok    (framing_ok),
	.error_code    (error_code),
	.checksum_ok   (checksum_ok),
	.type_match    (type_match),
	.constellation (constellation)
);
